FILE: design/pcen_pkg.sv
// Shared constants and types of the polygon centroid block.
package pcen_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int IN_BITS        = 16;
	localparam int AREA_BITS      = 44;
	localparam int MOMENT_BITS    = 61;
	localparam int OUT_AREA_BITS  = 43;
	localparam int CEN_BITS       = 24;
	localparam int FRAC_BITS      = 8;
	localparam int QUEUE_DEPTH    = 4;

	typedef struct packed {
		logic [AREA_BITS-1:0]   area;
		logic [MOMENT_BITS-1:0] mom_x;
		logic [MOMENT_BITS-1:0] mom_y;
	} sums_t;

	typedef struct packed {
		logic                     degenerate;
		logic [OUT_AREA_BITS-1:0] double_area;
		logic [CEN_BITS-1:0]      centroid_y;
		logic [CEN_BITS-1:0]      centroid_x;
	} result_t;

endpackage

FILE: design/pcen_front.sv
// Vertex intake: tracks first and previous vertex and tags each request.
module pcen_front #(
	parameter int COORD_BITS = pcen_pkg::COORD_BITS_DEF,
	localparam int EW = 6 * COORD_BITS + 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [pcen_pkg::IN_BITS-1:0] in_x,
	input  logic [pcen_pkg::IN_BITS-1:0] in_y,
	input  logic                         in_last,
	output logic                         push_valid,
	input  logic                         push_ready,
	output logic [EW-1:0]                push_data
);

	logic [COORD_BITS-1:0] x, y;
	logic [COORD_BITS-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [COORD_BITS-1:0] fx, fy;
	logic                  in_polygon_q;
	logic                  start;

	always_comb begin
		x          = in_x[COORD_BITS-1:0];
		y          = in_y[COORD_BITS-1:0];
		start      = !in_polygon_q;
		// a new polygon uses its own first vertex right away
		fx         = start ? x : first_x_q;
		fy         = start ? y : first_y_q;
		in_ready   = push_ready;
		push_valid = in_valid;
		// {start, last, first_y, first_x, prev_y, prev_x, y, x}
		push_data  = {start, in_last, fy, fx, prev_y_q, prev_x_q, y, x};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_polygon_q <= 1'b0;
			first_x_q    <= '0;
			first_y_q    <= '0;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
		end else if (in_valid && push_ready) begin
			prev_x_q     <= x;
			prev_y_q     <= y;
			first_x_q    <= fx;
			first_y_q    <= fy;
			in_polygon_q <= !in_last;
		end
	end

endmodule

FILE: design/pcen_queue.sv
// Small request queue between the vertex intake and the accumulator.
module pcen_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = pcen_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]    count_q;
	logic             do_wr, do_rd;

	always_comb begin
		wr_ready = count_q != NW'(DEPTH);
		rd_valid = count_q != '0;
		rd_data  = mem_q[rd_ptr_q];
		do_wr    = wr_valid && wr_ready;
		do_rd    = rd_valid && rd_ready;
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/pcen_accum.sv
// Edge sequencer and pipelined shoelace accumulator.
module pcen_accum #(
	parameter int COORD_BITS = pcen_pkg::COORD_BITS_DEF,
	localparam int EW = 6 * COORD_BITS + 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rd_valid,
	output logic            rd_ready,
	input  logic [EW-1:0]   rd_data,
	input  logic            div_busy,
	output logic            sums_valid,
	output pcen_pkg::sums_t sums
);

	localparam int CB = COORD_BITS;
	localparam int PB = 2 * CB;
	localparam int AB = 2 * CB + 1;
	localparam int SB = CB + 1;
	localparam int MB = 3 * CB + 2;

	logic signed [CB-1:0] e_x, e_y, e_px, e_py, e_fx, e_fy;
	logic                 e_start, e_last;
	logic                 closing_q;
	logic                 fin_busy, issue_main, issue_close;

	logic                 v_s1, clr_s1, fin_s1;
	logic signed [CB-1:0] x0_s1, y0_s1, x1_s1, y1_s1;
	logic                 v_s2, clr_s2, fin_s2;
	logic signed [PB-1:0] p1_s2, p2_s2;
	logic signed [SB-1:0] sx_s2, sy_s2;
	logic                 v_s3, clr_s3, fin_s3;
	logic signed [AB-1:0] a_s3;
	logic signed [SB-1:0] sx_s3, sy_s3;
	logic                 v_s4, clr_s4, fin_s4;
	logic signed [AB-1:0] a_s4;
	logic signed [MB-1:0] mx_s4, my_s4;

	logic [pcen_pkg::AREA_BITS-1:0]   area_q, area_n;
	logic [pcen_pkg::MOMENT_BITS-1:0] mom_x_q, mom_x_n, mom_y_q, mom_y_n;
	logic                             sums_valid_q;
	pcen_pkg::sums_t                  sums_q;

	always_comb begin
		e_x     = rd_data[0*CB +: CB];
		e_y     = rd_data[1*CB +: CB];
		e_px    = rd_data[2*CB +: CB];
		e_py    = rd_data[3*CB +: CB];
		e_fx    = rd_data[4*CB +: CB];
		e_fy    = rd_data[5*CB +: CB];
		e_last  = rd_data[6*CB];
		e_start = rd_data[6*CB+1];

		// only one closing edge may be in flight until the divider has finished with it
		fin_busy    = div_busy || sums_valid_q || (v_s1 && fin_s1) || (v_s2 && fin_s2) ||
		              (v_s3 && fin_s3) || (v_s4 && fin_s4);
		issue_main  = rd_valid && !closing_q;
		issue_close = rd_valid && closing_q && !fin_busy;
		rd_ready    = (issue_main && !e_last) || issue_close;

		area_n  = area_q + pcen_pkg::AREA_BITS'(a_s4);
		mom_x_n = mom_x_q + pcen_pkg::MOMENT_BITS'(mx_s4);
		mom_y_n = mom_y_q + pcen_pkg::MOMENT_BITS'(my_s4);

		sums_valid = sums_valid_q;
		sums       = sums_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closing_q    <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			v_s4         <= 1'b0;
			area_q       <= '0;
			mom_x_q      <= '0;
			mom_y_q      <= '0;
			sums_valid_q <= 1'b0;
		end else begin
			if (issue_main && e_last) begin
				closing_q <= 1'b1;
			end else if (issue_close) begin
				closing_q <= 1'b0;
			end
			v_s1 <= issue_main || issue_close;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;

			sums_valid_q <= 1'b0;
			if (v_s4) begin
				if (clr_s4) begin
					area_q  <= '0;
					mom_x_q <= '0;
					mom_y_q <= '0;
				end else if (fin_s4) begin
					area_q       <= '0;
					mom_x_q      <= '0;
					mom_y_q      <= '0;
					sums_valid_q <= 1'b1;
				end else begin
					area_q  <= area_n;
					mom_x_q <= mom_x_n;
					mom_y_q <= mom_y_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		// closing edge runs from the last vertex back to the first
		clr_s1 <= issue_main && e_start;
		fin_s1 <= issue_close;
		x0_s1  <= closing_q ? e_x : e_px;
		y0_s1  <= closing_q ? e_y : e_py;
		x1_s1  <= closing_q ? e_fx : e_x;
		y1_s1  <= closing_q ? e_fy : e_y;

		clr_s2 <= clr_s1;
		fin_s2 <= fin_s1;
		p1_s2  <= PB'(x0_s1) * PB'(y1_s1);
		p2_s2  <= PB'(x1_s1) * PB'(y0_s1);
		sx_s2  <= SB'(x0_s1) + SB'(x1_s1);
		sy_s2  <= SB'(y0_s1) + SB'(y1_s1);

		clr_s3 <= clr_s2;
		fin_s3 <= fin_s2;
		a_s3   <= AB'(p1_s2) - AB'(p2_s2);
		sx_s3  <= sx_s2;
		sy_s3  <= sy_s2;

		clr_s4 <= clr_s3;
		fin_s4 <= fin_s3;
		a_s4   <= a_s3;
		mx_s4  <= MB'(sx_s3) * MB'(a_s3);
		my_s4  <= MB'(sy_s3) * MB'(a_s3);

		if (v_s4 && fin_s4) begin
			sums_q.area  <= area_n;
			sums_q.mom_x <= mom_x_n;
			sums_q.mom_y <= mom_y_n;
		end
	end

endmodule

FILE: design/pcen_div.sv
// Two-lane restoring divider with saturation and the result register.
module pcen_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  pcen_pkg::sums_t   req,
	output logic              busy,
	output logic              out_valid,
	input  logic              out_ready,
	output pcen_pkg::result_t result
);

	localparam int AW = pcen_pkg::AREA_BITS;
	localparam int MW = pcen_pkg::MOMENT_BITS;
	localparam int OW = pcen_pkg::OUT_AREA_BITS;
	localparam int QW = pcen_pkg::CEN_BITS;
	localparam int FW = pcen_pkg::FRAC_BITS;
	localparam int SH = QW - FW;
	localparam int DW = AW + 2;
	localparam int CW = $clog2(QW);
	localparam logic [QW-1:0] MAX_POS = {1'b0, {(QW-1){1'b1}}};
	localparam logic [QW-1:0] MIN_NEG = {1'b1, {(QW-1){1'b0}}};
	localparam logic [OW-1:0] AMAX    = {1'b0, {(OW-1){1'b1}}};
	localparam logic [OW-1:0] AMIN    = {1'b1, {(OW-1){1'b0}}};

	typedef enum logic [2:0] {S_IDLE, S_PREP, S_INIT, S_RUN, S_FIN} state_t;

	state_t           state_q;
	logic [AW-1:0]    area_q;
	logic             zero_q;
	logic [MW-1:0]    mom_q [2];
	logic [MW-1:0]    mag_q [2];
	logic             neg_q [2];
	logic             ovf_q [2];
	logic [DW-1:0]    dmag_q;
	logic [DW-1:0]    rem_q [2];
	logic [QW-1:0]    low_q [2];
	logic [QW-1:0]    quo_q [2];
	logic [CW-1:0]    cnt_q;
	logic             out_valid_q;
	pcen_pkg::result_t result_q;

	logic signed [DW-1:0] area_ext, d3;
	logic [DW-1:0]        dmag;
	logic [MW-1:0]        mag [2];
	logic [DW-1:0]        r2 [2];
	logic                 ge [2];
	logic [QW-1:0]        cen [2];
	logic                 sat [2];
	logic                 area_sat, out_free;
	logic [OW-1:0]        area_out;

	always_comb begin
		area_ext = DW'($signed(area_q));
		d3       = area_ext + (area_ext <<< 1);
		dmag     = d3[DW-1] ? DW'(-d3) : DW'(d3);
		for (int i = 0; i < 2; i++) begin
			mag[i] = mom_q[i][MW-1] ? -mom_q[i] : mom_q[i];
			r2[i]  = {rem_q[i][DW-2:0], low_q[i][QW-1]};
			ge[i]  = r2[i] >= dmag_q;
			if (zero_q) begin
				sat[i] = 1'b0;
				cen[i] = '0;
			end else if (!neg_q[i]) begin
				sat[i] = ovf_q[i] || quo_q[i][QW-1];
				cen[i] = sat[i] ? MAX_POS : quo_q[i];
			end else begin
				sat[i] = ovf_q[i] || (quo_q[i] > MIN_NEG);
				cen[i] = sat[i] ? MIN_NEG : -quo_q[i];
			end
		end
		area_sat = area_q[AW-1] != area_q[AW-2];
		area_out = area_sat ? (area_q[AW-1] ? AMIN : AMAX) : area_q[OW-1:0];
		out_free = !out_valid_q || out_ready;
		busy     = state_q != S_IDLE;
		out_valid = out_valid_q;
		result    = result_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					state_q <= zero_q ? S_FIN : S_INIT;
				end
				S_INIT: begin
					cnt_q   <= CW'(QW - 1);
					state_q <= S_RUN;
				end
				S_RUN: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				area_q   <= req.area;
				zero_q   <= req.area == '0;
				mom_q[0] <= req.mom_x;
				mom_q[1] <= req.mom_y;
			end
			S_PREP: begin
				dmag_q <= dmag;
				for (int i = 0; i < 2; i++) begin
					mag_q[i] <= mag[i];
					neg_q[i] <= mom_q[i][MW-1] ^ d3[DW-1];
				end
			end
			S_INIT: begin
				// quotient of 2^QW or more cannot fit: flag it up front
				for (int i = 0; i < 2; i++) begin
					ovf_q[i] <= DW'(mag_q[i][MW-1:SH]) >= dmag_q;
					rem_q[i] <= DW'(mag_q[i][MW-1:SH]);
					low_q[i] <= {mag_q[i][SH-1:0], FW'(0)};
					quo_q[i] <= '0;
				end
			end
			S_RUN: begin
				for (int i = 0; i < 2; i++) begin
					rem_q[i] <= ge[i] ? r2[i] - dmag_q : r2[i];
					low_q[i] <= {low_q[i][QW-2:0], 1'b0};
					quo_q[i] <= {quo_q[i][QW-2:0], ge[i]};
				end
			end
			S_FIN: begin
				if (out_free) begin
					result_q.centroid_x  <= cen[0];
					result_q.centroid_y  <= cen[1];
					result_q.double_area <= area_out;
					result_q.degenerate  <= zero_q || sat[0] || sat[1] || area_sat;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: design/polygon_centroid_top.sv
// Polygon centroid block: vertex stream in, centroid and area out.
//
// Slave stream: one vertex per request, tdata = {vertex_y, vertex_x},
// tlast marks the final vertex of a polygon. Master stream: one result per
// polygon, tdata holds centroid_x, centroid_y (Q.8) and the doubled signed
// area; tuser is the degenerate flag (zero area or a saturated field).
// Vertices are accepted one per cycle while the queue has room; the front
// tags each one and hands it through a 4-entry queue to a 4-stage
// multiply/accumulate pipeline. A last vertex takes two pipeline slots (its
// own edge and the closing edge). The closing edge then feeds a two-lane
// restoring divider that retires one quotient bit per cycle. Vertices of
// the next polygon keep flowing while the divider works; a second closing
// edge waits until the divider has handed its result to the output
// register, and the queue then fills and drops tready. A stalled receiver
// holds the result register, which in turn holds the divider. Reset empties
// the queue and pipeline and starts a fresh polygon.
module polygon_centroid_top #(
	parameter int COORD_BITS = pcen_pkg::COORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // vertex_x [15:0], vertex_y [31:16]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,   // centroid_x, centroid_y, double_area, pad
	output logic        m_axis_tuser    // degenerate
);

	localparam int EW = 6 * COORD_BITS + 2;
	localparam int IB = pcen_pkg::IN_BITS;
	localparam int RB = 2 * pcen_pkg::CEN_BITS + pcen_pkg::OUT_AREA_BITS;

	logic              push_valid, push_ready, pop_valid, pop_ready;
	logic [EW-1:0]     push_data, pop_data;
	logic              div_busy, sums_valid;
	pcen_pkg::sums_t   sums;
	pcen_pkg::result_t result;

	pcen_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_x       (s_axis_tdata[IB-1:0]),
		.in_y       (s_axis_tdata[2*IB-1:IB]),
		.in_last    (s_axis_tlast),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	pcen_queue #(.WIDTH(EW), .DEPTH(pcen_pkg::QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_data  (push_data),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready),
		.rd_data  (pop_data)
	);

	pcen_accum #(.COORD_BITS(COORD_BITS)) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_valid   (pop_valid),
		.rd_ready   (pop_ready),
		.rd_data    (pop_data),
		.div_busy   (div_busy),
		.sums_valid (sums_valid),
		.sums       (sums)
	);

	pcen_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (sums_valid),
		.req       (sums),
		.busy      (div_busy),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.result    (result)
	);

	assign m_axis_tdata = {(96 - RB)'(0), result.double_area, result.centroid_y,
	                       result.centroid_x};
	assign m_axis_tuser = result.degenerate;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the polygon centroid block.
module tb_top;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int RANDOM_ITEMS  = 650;
	localparam int SHORT_ITEMS   = 150;
	localparam int LONG_VERTICES = 150;
	localparam int DRAIN_CYCLES  = 60;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;
	logic        m_axis_tuser;

	polygon_centroid_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #6 clk = ~clk;

	// predictor state
	longint            first_x, first_y, prev_x, prev_y;
	bit                poly_open;
	longint            area_acc, mom_x_acc, mom_y_acc;
	bit                sat_seen;
	pcen_pkg::result_t pending_centroids[$];

	int mismatches;
	int vertices_sent;
	int results_seen;
	int degenerate_seen;
	int cycle_count;

	// sender / receiver pacing
	bit gaps_on;
	int burst_left;
	bit rx_stall_on;
	logic [15:0] rx_pattern = 16'hffff;
	int rx_phase;
	int rx_hold;

	function automatic longint wrap_bits(longint v, int bits);
		return (v <<< (64 - bits)) >>> (64 - bits);
	endfunction

	function automatic longint clamp_signed(longint v, int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			sat_seen = 1'b1;
			return hi;
		end
		if (v < lo) begin
			sat_seen = 1'b1;
			return lo;
		end
		return v;
	endfunction

	function automatic void accumulate_edge(longint x0, longint y0, longint x1, longint y1);
		longint a;
		a = x0 * y1 - x1 * y0;
		area_acc  = wrap_bits(area_acc + a, pcen_pkg::AREA_BITS);
		mom_x_acc = wrap_bits(mom_x_acc + (x0 + x1) * a, pcen_pkg::MOMENT_BITS);
		mom_y_acc = wrap_bits(mom_y_acc + (y0 + y1) * a, pcen_pkg::MOMENT_BITS);
	endfunction

	// truncated Q.8 quotient; integer part clamped first so the product cannot overflow
	function automatic longint q8_quotient(longint m, longint d);
		longint lim;
		longint q;
		longint r;
		longint f;
		lim = longint'(1) <<< (pcen_pkg::CEN_BITS - pcen_pkg::FRAC_BITS);
		q = m / d;
		r = m % d;
		f = (r * (longint'(1) <<< pcen_pkg::FRAC_BITS)) / d;
		if (q > lim)
			q = lim;
		if (q < -lim - 1)
			q = -lim - 1;
		return clamp_signed(q * (longint'(1) <<< pcen_pkg::FRAC_BITS) + f, pcen_pkg::CEN_BITS);
	endfunction

	task automatic shoelace_predict(input logic signed [15:0] vx, input logic signed [15:0] vy,
			input logic last);
		longint            x;
		longint            y;
		longint            cx;
		longint            cy;
		longint            ar;
		pcen_pkg::result_t r;
		x = longint'(vx);
		y = longint'(vy);
		if (!poly_open) begin
			first_x = x;
			first_y = y;
			area_acc = 0;
			mom_x_acc = 0;
			mom_y_acc = 0;
			poly_open = 1'b1;
		end else begin
			accumulate_edge(prev_x, prev_y, x, y);
		end
		prev_x = x;
		prev_y = y;
		if (last) begin
			accumulate_edge(x, y, first_x, first_y);
			sat_seen = 1'b0;
			cx = 0;
			cy = 0;
			if (area_acc == 0) begin
				sat_seen = 1'b1;
			end else begin
				cx = q8_quotient(mom_x_acc, 3 * area_acc);
				cy = q8_quotient(mom_y_acc, 3 * area_acc);
			end
			ar = clamp_signed(area_acc, pcen_pkg::OUT_AREA_BITS);
			r.centroid_x  = cx[pcen_pkg::CEN_BITS-1:0];
			r.centroid_y  = cy[pcen_pkg::CEN_BITS-1:0];
			r.double_area = ar[pcen_pkg::OUT_AREA_BITS-1:0];
			r.degenerate  = sat_seen;
			pending_centroids.push_back(r);
			poly_open = 1'b0;
			area_acc = 0;
			mom_x_acc = 0;
			mom_y_acc = 0;
		end
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		mismatches++;
		if (mismatches <= 30)
			$display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want,
				results_seen);
	endtask

	// entered and left at a falling edge; valid stays high within a burst
	task automatic send_vertex(input logic signed [15:0] x, input logic signed [15:0] y,
			input logic last);
		int gap;
		s_axis_tdata  <= {y, x};
		s_axis_tlast  <= last;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		shoelace_predict(x, y, last);
		vertices_sent++;
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 15);
			gap = gaps_on ? $urandom_range(0, 8) : 0;
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// 0: full range, 1: near origin, 2: near the extremes
	function automatic logic signed [15:0] rand_coord(int style);
		logic signed [15:0] c;
		case (style)
			0: c = 16'($urandom);
			1: c = 16'(int'($urandom_range(0, 100)) - 50);
			default: begin
				if ($urandom_range(0, 1))
					c = 16'sh7fff - 16'($urandom_range(0, 15));
				else
					c = 16'sh8000 + 16'($urandom_range(0, 15));
			end
		endcase
		return c;
	endfunction

	// receiver: rotating random stall mask, now and then a long hold
	always @(negedge clk) begin
		if (!rx_stall_on) begin
			m_axis_tready <= 1'b1;
		end else if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= rx_pattern[0];
			rx_phase <= (rx_phase + 1) % 16;
			if (rx_phase == 15) begin
				rx_pattern <= 16'($urandom);
				if ($urandom_range(0, 3) == 0)
					rx_hold <= $urandom_range(8, 60);
			end else begin
				rx_pattern <= {rx_pattern[0], rx_pattern[15:1]};
			end
		end
	end

	always @(posedge clk) begin
		pcen_pkg::result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (m_axis_tuser)
				degenerate_seen++;
			if (pending_centroids.size() == 0) begin
				report("unexpected result", m_axis_tdata[63:0], '0);
			end else begin
				want = pending_centroids.pop_front();
				if (m_axis_tdata[23:0] !== want.centroid_x)
					report("centroid_x", 64'(m_axis_tdata[23:0]), 64'(want.centroid_x));
				if (m_axis_tdata[47:24] !== want.centroid_y)
					report("centroid_y", 64'(m_axis_tdata[47:24]), 64'(want.centroid_y));
				if (m_axis_tdata[90:48] !== want.double_area)
					report("double_area", 64'(m_axis_tdata[90:48]),
						64'(want.double_area));
				if (m_axis_tuser !== want.degenerate)
					report("degenerate", 64'(m_axis_tuser), 64'(want.degenerate));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_centroids.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic test_directed_shapes();
		// lone vertex: closing edge to itself, zero area
		send_vertex(16'sh7fff, 16'sh8000, 1'b1);
		// extreme triangle, counterclockwise then clockwise
		send_vertex(16'sh8000, 16'sh8000, 1'b0);
		send_vertex(16'sh7fff, 16'sh8000, 1'b0);
		send_vertex(16'sh7fff, 16'sh7fff, 1'b1);
		send_vertex(16'sh8000, 16'sh8000, 1'b0);
		send_vertex(16'sh7fff, 16'sh7fff, 1'b0);
		send_vertex(16'sh7fff, 16'sh8000, 1'b1);
		// collinear points
		send_vertex(-16'sd5, -16'sd10, 1'b0);
		send_vertex(16'sd1, 16'sd2, 1'b0);
		send_vertex(16'sd7, 16'sd14, 1'b1);
		// two vertices: an edge and its way back
		send_vertex(16'sd300, -16'sd7, 1'b0);
		send_vertex(-16'sd9, 16'sd1000, 1'b1);
		// full-range square
		send_vertex(16'sh7fff, 16'sh7fff, 1'b0);
		send_vertex(16'sh8000, 16'sh7fff, 1'b0);
		send_vertex(16'sh8000, 16'sh8000, 1'b0);
		send_vertex(16'sh7fff, 16'sh8000, 1'b1);
		// crossed quad with near-zero net area: centroid far out, saturates
		send_vertex(16'sd0, 16'sd0, 1'b0);
		send_vertex(16'sd30000, 16'sd30000, 1'b0);
		send_vertex(16'sd30000, 16'sd0, 1'b0);
		send_vertex(16'sd0, 16'sd30001, 1'b1);
		// same shape small enough to stay in range
		send_vertex(16'sd0, 16'sd0, 1'b0);
		send_vertex(16'sd10, 16'sd10, 1'b0);
		send_vertex(16'sd10, 16'sd0, 1'b0);
		send_vertex(16'sd0, 16'sd11, 1'b1);
	endtask

	task automatic test_random_polygons(int items);
		int count;
		int len;
		int style;
		int pick;
		count = 0;
		while (count < items) begin
			if ($urandom_range(0, 15) == 0) begin
				gaps_on = 1'($urandom_range(0, 1));
				rx_stall_on = 1'($urandom_range(0, 1));
			end
			pick = $urandom_range(0, 19);
			if (pick < 3)
				len = $urandom_range(1, 2);
			else if (pick < 17)
				len = $urandom_range(3, 8);
			else
				len = $urandom_range(9, 40);
			style = $urandom_range(0, 2);
			for (int i = 0; i < len; i++) begin
				// occasional vertex from another range to mix scales
				if ($urandom_range(0, 7) == 0)
					send_vertex(rand_coord($urandom_range(0, 2)), rand_coord(style),
						i == len - 1);
				else
					send_vertex(rand_coord(style), rand_coord(style), i == len - 1);
			end
			count += len;
		end
	endtask

	// many tiny polygons back to back against a stalling receiver fill the queue
	task automatic test_short_polygons_backpressure(int items);
		int len;
		int count;
		gaps_on = 1'b0;
		rx_stall_on = 1'b1;
		count = 0;
		while (count < items) begin
			len = $urandom_range(1, 3);
			for (int i = 0; i < len; i++)
				send_vertex(rand_coord(0), rand_coord(0), i == len - 1);
			count += len;
		end
	endtask

	// square walked round and round: one long polygon with large running sums
	task automatic test_long_winding(bit ccw);
		logic signed [15:0] xs[4];
		logic signed [15:0] ys[4];
		int k;
		xs = '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff};
		ys = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000};
		for (int i = 0; i < LONG_VERTICES; i++) begin
			k = ccw ? (i % 4) : (3 - (i % 4));
			send_vertex(xs[k], ys[k], i == LONG_VERTICES - 1);
		end
	endtask

	initial begin
		gaps_on = 1'b0;
		rx_stall_on = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_shapes();
		gaps_on = 1'b1;
		rx_stall_on = 1'b1;
		test_random_polygons(RANDOM_ITEMS);
		test_short_polygons_backpressure(SHORT_ITEMS);
		gaps_on = 1'b1;
		rx_stall_on = 1'b1;
		test_long_winding(1'b1);
		test_long_winding(1'b0);

		s_axis_tvalid <= 1'b0;
		while (pending_centroids.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d vertices; checked %0d polygon results, %0d flagged degenerate.",
			vertices_sent, results_seen, degenerate_seen);
		$display("Mix: directed extremes, random shapes, short bursts, two long windings.");
		if (mismatches == 0 && pending_centroids.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: polygon_centroid_top.f
design/pcen_pkg.sv
design/pcen_front.sv
design/pcen_queue.sv
design/pcen_accum.sv
design/pcen_div.sv
design/polygon_centroid_top.sv
tb/tb_top.sv
